// ===== rtl/core/bap_pkg.sv =====
// Shared types and constants for the block-average pixelate core.
package bap_pkg;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 4;
    localparam int POS_W      = 12;
    localparam int EDGE_W     = 7;
    localparam int OUT_IDX_W  = 9;
    localparam int OUT_EDGE_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = 2'd3;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [10:0] FRAME_HEIGHT_RST = 11'd1024;
    localparam logic [4:0]  BLOCK_SIZE_RST   = 5'd8;

    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;
    localparam int CH_ALPHA = 3;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [4:0]  block_size;
        logic        has_alpha;
    } t_cfg;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [EDGE_W-1:0] bw;
        logic [EDGE_W-1:0] bh;
        logic              first;
        logic              blk_end;
        logic              frame_done;
    } t_blk;

endpackage

// ===== rtl/core/block_average_pixelate_core.sv =====
// Block-average pixelate core: block tiling, channel sums and mean output.
// Pixels inside a block are taken one per cycle unless a finished block is being averaged; the sum memory is read at
// acceptance and written back the next cycle, with forwarding on the same column.
// A block's last pixel stalls input through the sum update, 8 divider steps and the hand-off,
// which waits while the output is stalled; the result is registered at the outputs on
// hand-off. Synchronous reset restores register defaults and the frame.
module block_average_pixelate_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bap_pkg::PIX_W-1:0]         i_blue,
    input  logic [bap_pkg::PIX_W-1:0]         i_green,
    input  logic [bap_pkg::PIX_W-1:0]         i_red,
    input  logic [bap_pkg::PIX_W-1:0]         i_alpha,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bap_pkg::OUT_IDX_W-1:0]     o_block_col,
    output logic [bap_pkg::OUT_IDX_W-1:0]     o_block_row,
    output logic [bap_pkg::OUT_EDGE_W-1:0]    o_block_w,
    output logic [bap_pkg::OUT_EDGE_W-1:0]    o_block_h,
    output logic [bap_pkg::PIX_W-1:0]         o_avg_blue,
    output logic [bap_pkg::PIX_W-1:0]         o_avg_green,
    output logic [bap_pkg::PIX_W-1:0]         o_avg_red,
    output logic [bap_pkg::PIX_W-1:0]         o_avg_alpha,
    output logic                              o_frame_done
);
    import bap_pkg::*;

    localparam int CC  = (MAX_WIDTH + 1) / 2;
    localparam int CIW = (CC > 1) ? $clog2(CC) : 1;
    localparam int EW  = $clog2(MAX_BLOCK + 1);
    localparam int SW  = PIX_W + 2 * $clog2(MAX_BLOCK);

    t_cfg                      r_cfg;
    t_blk                      pos_info;
    t_blk                      r_s1_info;
    logic                      r_s1_valid;
    t_blk                      r_div_info;
    t_pix                      px;
    logic [NUM_CH-1:0][SW-1:0] sum;
    t_pix                      avg;
    logic                      in_acc;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic                      out_load;

    assign o_stall   = (r_s1_valid && r_s1_info.blk_end) || div_busy;
    assign in_acc    = i_valid && !o_stall;
    assign div_start = r_s1_valid && r_s1_info.blk_end;
    assign out_load  = div_done && (!o_valid || !i_stall);

    always_comb begin
        px[CH_BLUE]  = i_blue;
        px[CH_GREEN] = i_green;
        px[CH_RED]   = i_red;
        px[CH_ALPHA] = r_cfg.has_alpha ? i_alpha : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= FRAME_WIDTH_RST;
            r_cfg.frame_height <= FRAME_HEIGHT_RST;
            r_cfg.block_size   <= BLOCK_SIZE_RST;
            r_cfg.has_alpha    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_wdata;
                REG_BLOCK_SIZE:   r_cfg.block_size   <= i_cfg_wdata[4:0];
                REG_HAS_ALPHA:    r_cfg.has_alpha    <= i_cfg_wdata[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    bap_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_BLOCK  (MAX_BLOCK)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_wr_en),
        .i_advance (in_acc),
        .i_cfg     (r_cfg),
        .o_info    (pos_info)
    );

    bap_sums #(
        .DEPTH (CC),
        .SW    (SW)
    ) u_sums (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_addr  (pos_info.col[CIW-1:0]),
        .i_first (pos_info.first),
        .i_px    (px),
        .o_sum   (sum)
    );

    bap_div #(
        .MAX_BLOCK (MAX_BLOCK),
        .SW        (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_clear (out_load),
        .i_sum   (sum),
        .i_bw    (r_s1_info.bw[EW-1:0]),
        .i_bh    (r_s1_info.bh[EW-1:0]),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_avg   (avg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_info <= pos_info;
        end
        if (div_start) begin
            r_div_info <= r_s1_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_block_col  <= r_div_info.col[OUT_IDX_W-1:0];
            o_block_row  <= r_div_info.row[OUT_IDX_W-1:0];
            o_block_w    <= r_div_info.bw[OUT_EDGE_W-1:0];
            o_block_h    <= r_div_info.bh[OUT_EDGE_W-1:0];
            o_avg_blue   <= avg[CH_BLUE];
            o_avg_green  <= avg[CH_GREEN];
            o_avg_red    <= avg[CH_RED];
            o_avg_alpha  <= avg[CH_ALPHA];
            o_frame_done <= r_div_info.frame_done;
        end
    end

endmodule

// ===== rtl/core/bap_pos.sv =====
// Raster position, block and band counters with clamped frame geometry.
module bap_pos #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_BLOCK  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_restart,
    input  logic          i_advance,
    input  bap_pkg::t_cfg i_cfg,
    output bap_pkg::t_blk o_info
);
    import bap_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int EW  = $clog2(MAX_BLOCK + 1);
    localparam int BW  = $clog2(MAX_BLOCK);
    localparam int CC  = (MAX_WIDTH + 1) / 2;
    localparam int RC  = (MAX_HEIGHT + 1) / 2;
    localparam int CIW = (CC > 1) ? $clog2(CC) : 1;
    localparam int RIW = (RC > 1) ? $clog2(RC) : 1;

    logic [XW-1:0]  r_x;
    logic [YW-1:0]  r_y;
    logic [BW-1:0]  r_cib;
    logic [BW-1:0]  r_rib;
    logic [CIW-1:0] r_bi;
    logic [RIW-1:0] r_bn;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [EW-1:0] blk_edge;
    logic          last_x;
    logic          last_y;
    logic          col_end;
    logic          row_end;

    always_comb begin
        if (i_cfg.frame_width == '0) begin
            eff_w = WW'(1);
        end else if (int'(i_cfg.frame_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            eff_h = HW'(1);
        end else if (int'(i_cfg.frame_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(i_cfg.frame_height);
        end
        if (int'(i_cfg.block_size) > MAX_BLOCK) begin
            blk_edge = EW'(MAX_BLOCK);
        end else begin
            blk_edge = EW'(i_cfg.block_size);
        end
        if (int'(blk_edge) > int'(eff_w)) begin
            blk_edge = EW'(eff_w);
        end
        if (blk_edge < EW'(2)) begin
            blk_edge = EW'(2);
        end
    end

    assign last_x  = (int'(r_x) + 1) >= int'(eff_w);
    assign last_y  = (int'(r_y) + 1) >= int'(eff_h);
    assign col_end = ((int'(r_cib) + 1) >= int'(blk_edge)) || last_x;
    assign row_end = ((int'(r_rib) + 1) >= int'(blk_edge)) || last_y;

    always_comb begin
        o_info.col        = POS_W'(r_bi);
        o_info.row        = POS_W'(r_bn);
        o_info.bw         = EDGE_W'(r_cib) + EDGE_W'(1);
        o_info.bh         = EDGE_W'(r_rib) + EDGE_W'(1);
        o_info.first      = (r_cib == '0) && (r_rib == '0);
        o_info.blk_end    = col_end && row_end;
        o_info.frame_done = last_x && last_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_x   <= '0;
            r_y   <= '0;
            r_cib <= '0;
            r_rib <= '0;
            r_bi  <= '0;
            r_bn  <= '0;
        end else if (i_advance) begin
            if (last_x) begin
                r_x   <= '0;
                r_cib <= '0;
                r_bi  <= '0;
                if (last_y) begin
                    r_y   <= '0;
                    r_rib <= '0;
                    r_bn  <= '0;
                end else begin
                    r_y <= r_y + YW'(1);
                    if (row_end) begin
                        r_rib <= '0;
                        r_bn  <= r_bn + RIW'(1);
                    end else begin
                        r_rib <= r_rib + BW'(1);
                    end
                end
            end else begin
                r_x <= r_x + XW'(1);
                if (col_end) begin
                    r_cib <= '0;
                    r_bi  <= r_bi + CIW'(1);
                end else begin
                    r_cib <= r_cib + BW'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/core/bap_sums.sv =====
// Per-block-column channel sum memory with read-modify-write and forwarding.
module bap_sums #(
    parameter int DEPTH = 512,
    parameter int SW    = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_acc,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic                                      i_first,
    input  bap_pkg::t_pix                             i_px,
    output logic [bap_pkg::NUM_CH-1:0][SW-1:0]        o_sum
);
    import bap_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [NUM_CH-1:0][SW-1:0] r_mem [DEPTH];
    logic [NUM_CH-1:0][SW-1:0] r_rd;
    logic [AW-1:0]             r_addr;
    logic                      r_first;
    t_pix                      r_px;
    logic                      r_valid;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_first) begin
                o_sum[c] = SW'(r_px[c]);
            end else begin
                o_sum[c] = r_rd[c] + SW'(r_px[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_valid) begin
            r_mem[r_addr] <= o_sum;
        end
        if (i_acc) begin
            r_addr  <= i_addr;
            r_first <= i_first;
            r_px    <= i_px;
            if (r_valid && (r_addr == i_addr)) begin
                r_rd <= o_sum;
            end else begin
                r_rd <= r_mem[i_addr];
            end
        end
    end

endmodule

// ===== rtl/core/bap_div.sv =====
// Iterative restoring divider for the four channel means, one quotient bit per cycle.
module bap_div #(
    parameter int MAX_BLOCK = 16,
    parameter int SW        = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_clear,
    input  logic [bap_pkg::NUM_CH-1:0][SW-1:0]     i_sum,
    input  logic [$clog2(MAX_BLOCK + 1)-1:0]       i_bw,
    input  logic [$clog2(MAX_BLOCK + 1)-1:0]       i_bh,
    output logic                                   o_busy,
    output logic                                   o_done,
    output bap_pkg::t_pix                          o_avg
);
    import bap_pkg::*;

    localparam int EW  = $clog2(MAX_BLOCK + 1);
    localparam int CW  = 2 * EW;
    localparam int DW  = CW + PIX_W;
    localparam int STW = $clog2(PIX_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [NUM_CH-1:0][DW-1:0] r_rem;
    logic [DW-1:0]        r_dvs;
    logic [STW-1:0]       r_step;
    t_pix                 r_q;
    logic [CW-1:0]        cnt;
    logic [NUM_CH-1:0]    ge;

    assign cnt = CW'(i_bw) * CW'(i_bh);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            ge[c] = r_rem[c] >= r_dvs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        for (int c = 0; c < NUM_CH; c++) begin
                            r_rem[c] <= DW'(i_sum[c]);
                        end
                        r_dvs   <= {1'b0, cnt, {(PIX_W - 1){1'b0}}};
                        r_step  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (ge[c]) begin
                            r_rem[c] <= r_rem[c] - r_dvs;
                        end
                        r_q[c] <= {r_q[c][PIX_W-2:0], ge[c]};
                    end
                    r_dvs  <= r_dvs >> 1;
                    r_step <= r_step + STW'(1);
                    if (r_step == STW'(PIX_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_clear) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_avg  = r_q;

endmodule
